>>> hw/rtl/tawf_pkg.sv
// Shared constants and the arctangent table for the track angle pipeline.
package tawf_pkg;

    localparam int MOM_W        = 24;
    localparam int UNIT_FRAC    = 14;
    localparam int UNIT_W       = UNIT_FRAC + 2;
    localparam int ANGLE_FRAC   = 13;
    localparam int ANGLE_W      = ANGLE_FRAC + 2;
    localparam int Q_FRAC       = 30;
    localparam int CORDIC_STEPS = 30;
    localparam int ROOT_IN_W    = 64;
    localparam int ROOT_W       = 32;
    localparam int ROOT_STEPS   = 32;
    localparam int CORD_IN_W    = Q_FRAC + 1;

    localparam logic [31:0] PI_Q30      = 32'd3373259426;
    localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;

    localparam logic [ANGLE_W-1:0] ANGLE_PI = ANGLE_W'((64'(PI_Q30)
        + (64'd1 << (Q_FRAC - 1 - ANGLE_FRAC))) >> (Q_FRAC - ANGLE_FRAC));

    // atan(2^-i) in Q30, truncated
    function automatic logic [31:0] atan_q30(input int unsigned i);
        logic [31:0] v;
        case (i)
            0: v = 32'd843314856;
            1: v = 32'd497837829;
            2: v = 32'd263043836;
            3: v = 32'd133525158;
            4: v = 32'd67021686;
            5: v = 32'd33543515;
            6: v = 32'd16775850;
            7: v = 32'd8388437;
            8: v = 32'd4194282;
            9: v = 32'd2097149;
            default: v = (32'd1 << (Q_FRAC - i)) - 32'd1;
        endcase
        return v;
    endfunction

endpackage

>>> hw/rtl/tawf_isqrt.sv
// Pipelined integer square root, one result bit per stage.
module tawf_isqrt #(
    parameter int TAG_W = 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic [tawf_pkg::ROOT_IN_W-1:0] in_val,
    input  logic [TAG_W-1:0]               in_tag,
    output logic                           out_valid,
    output logic [tawf_pkg::ROOT_W-1:0]    out_root,
    output logic [TAG_W-1:0]               out_tag
);
    import tawf_pkg::*;

    localparam logic [ROOT_IN_W-1:0] ONE_W = ROOT_IN_W'(1);

    logic [ROOT_STEPS:0]    valid_reg;
    logic [ROOT_IN_W-1:0]   rem_reg  [ROOT_STEPS+1];
    logic [ROOT_IN_W-1:0]   root_reg [ROOT_STEPS+1];
    logic [TAG_W-1:0]       tag_reg  [ROOT_STEPS+1];
    logic [ROOT_IN_W-1:0]   rem_next  [ROOT_STEPS];
    logic [ROOT_IN_W-1:0]   root_next [ROOT_STEPS];

    always_comb
    begin
        for (int j = 0; j < ROOT_STEPS; j++)
        begin
            logic [ROOT_IN_W-1:0] bitv;
            logic [ROOT_IN_W-1:0] trial;
            bitv  = ONE_W << (ROOT_IN_W - 2 - 2 * j);
            trial = root_reg[j] + bitv;
            if (rem_reg[j] >= trial)
            begin
                rem_next[j]  = rem_reg[j] - trial;
                root_next[j] = (root_reg[j] >> 1) + bitv;
            end
            else
            begin
                rem_next[j]  = rem_reg[j];
                root_next[j] = root_reg[j] >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[ROOT_STEPS-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= in_val;
        root_reg[0] <= '0;
        tag_reg[0]  <= in_tag;
        for (int j = 0; j < ROOT_STEPS; j++)
        begin
            rem_reg[j+1]  <= rem_next[j];
            root_reg[j+1] <= root_next[j];
            tag_reg[j+1]  <= tag_reg[j];
        end
    end

    assign out_valid = valid_reg[ROOT_STEPS];
    assign out_root  = root_reg[ROOT_STEPS][ROOT_W-1:0];
    assign out_tag   = tag_reg[ROOT_STEPS];

endmodule

>>> hw/rtl/tawf_cordic.sv
// Pipelined CORDIC vectoring: atan(y/x) in Q30, optional pi minus, rounded angle.
module tawf_cordic #(
    parameter int TAG_W = 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic [tawf_pkg::CORD_IN_W-1:0] in_x,
    input  logic [tawf_pkg::CORD_IN_W-1:0] in_y,
    input  logic                           in_neg,
    input  logic [TAG_W-1:0]               in_tag,
    output logic                           out_valid,
    output logic [tawf_pkg::ANGLE_W-1:0]   out_angle,
    output logic [TAG_W-1:0]               out_tag
);
    import tawf_pkg::*;

    localparam int XW = CORD_IN_W + 3;
    localparam int ZW = 33;

    logic [CORDIC_STEPS:0]  valid_reg;
    logic signed [XW-1:0]   x_reg   [CORDIC_STEPS+1];
    logic signed [XW-1:0]   y_reg   [CORDIC_STEPS+1];
    logic signed [ZW-1:0]   z_reg   [CORDIC_STEPS+1];
    logic                   neg_reg [CORDIC_STEPS+1];
    logic [TAG_W-1:0]       tag_reg [CORDIC_STEPS+1];
    logic signed [XW-1:0]   x_next  [CORDIC_STEPS];
    logic signed [XW-1:0]   y_next  [CORDIC_STEPS];
    logic signed [ZW-1:0]   z_next  [CORDIC_STEPS];

    logic                   out_valid_reg;
    logic [ANGLE_W-1:0]     angle_reg;
    logic [TAG_W-1:0]       out_tag_reg;
    logic [ANGLE_W-1:0]     angle_next;

    always_comb
    begin
        for (int j = 0; j < CORDIC_STEPS; j++)
        begin
            logic signed [XW-1:0] dx;
            logic signed [XW-1:0] dy;
            logic signed [ZW-1:0] da;
            // shifts truncate toward zero
            dx = (y_reg[j] >= 0) ? (y_reg[j] >>> j) : -((-y_reg[j]) >>> j);
            dy = (x_reg[j] >= 0) ? (x_reg[j] >>> j) : -((-x_reg[j]) >>> j);
            da = signed'({1'b0, atan_q30(j)});
            if (y_reg[j] >= 0)
            begin
                x_next[j] = x_reg[j] + dx;
                y_next[j] = y_reg[j] - dy;
                z_next[j] = z_reg[j] + da;
            end
            else
            begin
                x_next[j] = x_reg[j] - dx;
                y_next[j] = y_reg[j] + dy;
                z_next[j] = z_reg[j] - da;
            end
        end
    end

    always_comb
    begin
        logic signed [ZW-1:0] zf;
        logic [31:0]          zc;
        logic [31:0]          a;
        logic [32:0]          rnd;
        zf = z_reg[CORDIC_STEPS];
        if (zf < 0)
            zc = '0;
        else if (zf > signed'({1'b0, HALF_PI_Q30}))
            zc = HALF_PI_Q30;
        else
            zc = zf[31:0];
        a = neg_reg[CORDIC_STEPS] ? (PI_Q30 - zc) : zc;
        rnd = ({1'b0, a} + (33'd1 << (Q_FRAC - 1 - ANGLE_FRAC))) >> (Q_FRAC - ANGLE_FRAC);
        angle_next = rnd[ANGLE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= {valid_reg[CORDIC_STEPS-1:0], in_valid};
            out_valid_reg <= valid_reg[CORDIC_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg[0]   <= XW'(signed'({1'b0, in_x}));
        y_reg[0]   <= XW'(signed'({1'b0, in_y}));
        z_reg[0]   <= '0;
        neg_reg[0] <= in_neg;
        tag_reg[0] <= in_tag;
        for (int j = 0; j < CORDIC_STEPS; j++)
        begin
            x_reg[j+1]   <= x_next[j];
            y_reg[j+1]   <= y_next[j];
            z_reg[j+1]   <= z_next[j];
            neg_reg[j+1] <= neg_reg[j];
            tag_reg[j+1] <= tag_reg[j];
        end
        angle_reg   <= angle_next;
        out_tag_reg <= tag_reg[CORDIC_STEPS];
    end

    assign out_valid = out_valid_reg;
    assign out_angle = angle_reg;
    assign out_tag   = out_tag_reg;

endmodule

>>> hw/rtl/track_angles_to_wafer_frame.sv
// Top level: polar and in-plane angles of a track momentum in a wafer frame.
//
//  channel  | handshake      | payload
//  ---------+----------------+---------------------------------------------------
//  input    | start / busy   | mom_x/y/z, normal_x/y/z, drift_x/y/z, transverse_x/y/z
//  result   | done (strobe)  | theta, phi, theta_invalid, phi_invalid
//
// One beat accepted per cycle; busy stays low. Each result passes through dot products
// (4 stages), momentum-length root (33), cosine divider (31), square (1), sine root (33),
// CORDIC (32).
// Reset clears all valid bits; beats in flight are dropped.
// The receiver cannot stall, so the pipeline never holds.
module track_angles_to_wafer_frame (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [tawf_pkg::MOM_W-1:0]   mom_x,
    input  logic signed [tawf_pkg::MOM_W-1:0]   mom_y,
    input  logic signed [tawf_pkg::MOM_W-1:0]   mom_z,
    input  logic signed [tawf_pkg::UNIT_W-1:0]  normal_x,
    input  logic signed [tawf_pkg::UNIT_W-1:0]  normal_y,
    input  logic signed [tawf_pkg::UNIT_W-1:0]  normal_z,
    input  logic signed [tawf_pkg::UNIT_W-1:0]  drift_x,
    input  logic signed [tawf_pkg::UNIT_W-1:0]  drift_y,
    input  logic signed [tawf_pkg::UNIT_W-1:0]  drift_z,
    input  logic signed [tawf_pkg::UNIT_W-1:0]  transverse_x,
    input  logic signed [tawf_pkg::UNIT_W-1:0]  transverse_y,
    input  logic signed [tawf_pkg::UNIT_W-1:0]  transverse_z,
    output logic                                done,
    output logic [tawf_pkg::ANGLE_W-1:0]        theta,
    output logic [tawf_pkg::ANGLE_W-1:0]        phi,
    output logic                                theta_invalid,
    output logic                                phi_invalid
);
    import tawf_pkg::*;

    localparam int PROD_W    = MOM_W + UNIT_W;
    localparam int SQP_W     = 2 * MOM_W;
    localparam int DOT_W     = PROD_W + 2;
    localparam int SQ_W      = SQP_W + 2;
    localparam int NUM_W     = DOT_W + Q_FRAC;
    localparam int DEN_W     = ROOT_W + UNIT_FRAC;
    localparam int REM_W     = DEN_W + 1;
    localparam int DIV_STEPS = Q_FRAC;
    localparam int PHI_W     = 2 * Q_FRAC + 2;
    localparam int TAG1_W    = NUM_W + 2 + PHI_W;
    localparam int TAG2_W    = CORD_IN_W + 2 + PHI_W;
    localparam int LATENCY   = 4 + 2 * (ROOT_STEPS + 1) + (DIV_STEPS + 1) + 1
                               + (CORDIC_STEPS + 2);
    localparam logic [6:0] NORM_TOP = 7'(2 * Q_FRAC + 2);
    localparam logic [6:0] PHI_TOP  = 7'(Q_FRAC);

    function automatic logic [6:0] bit_len(input logic [63:0] v);
        logic [6:0] n;
        n = '0;
        for (int i = 0; i < 64; i++)
        begin
            if (v[i])
                n = 7'(i + 1);
        end
        return n;
    endfunction

    // stage 1: products
    logic signed [MOM_W-1:0]  mom [3];
    logic signed [UNIT_W-1:0] nrm [3];
    logic signed [UNIT_W-1:0] drf [3];
    logic signed [UNIT_W-1:0] trv [3];
    logic                     v1_reg;
    logic signed [PROD_W-1:0] mn_reg [3];
    logic signed [PROD_W-1:0] md_reg [3];
    logic signed [PROD_W-1:0] mt_reg [3];
    logic signed [SQP_W-1:0]  mm_reg [3];

    assign busy = 1'b0;

    always_comb
    begin
        mom[0] = mom_x;        mom[1] = mom_y;        mom[2] = mom_z;
        nrm[0] = normal_x;     nrm[1] = normal_y;     nrm[2] = normal_z;
        drf[0] = drift_x;      drf[1] = drift_y;      drf[2] = drift_z;
        trv[0] = transverse_x; trv[1] = transverse_y; trv[2] = transverse_z;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            mn_reg[i] <= PROD_W'(mom[i]) * PROD_W'(nrm[i]);
            md_reg[i] <= PROD_W'(mom[i]) * PROD_W'(drf[i]);
            mt_reg[i] <= PROD_W'(mom[i]) * PROD_W'(trv[i]);
            mm_reg[i] <= SQP_W'(mom[i]) * SQP_W'(mom[i]);
        end
    end

    // stage 2: sums
    logic                    v2_reg;
    logic signed [DOT_W-1:0] dn_reg, dd_reg, dt_reg;
    logic [SQ_W-1:0]         m2_reg;

    always_ff @(posedge clk)
    begin
        dn_reg <= DOT_W'(mn_reg[0]) + DOT_W'(mn_reg[1]) + DOT_W'(mn_reg[2]);
        dd_reg <= DOT_W'(md_reg[0]) + DOT_W'(md_reg[1]) + DOT_W'(md_reg[2]);
        dt_reg <= DOT_W'(mt_reg[0]) + DOT_W'(mt_reg[1]) + DOT_W'(mt_reg[2]);
        m2_reg <= SQ_W'($unsigned(mm_reg[0])) + SQ_W'($unsigned(mm_reg[1]))
                  + SQ_W'($unsigned(mm_reg[2]));
    end

    // stage 3: magnitudes and leading-one positions
    logic              v3_reg;
    logic [SQ_W-1:0]   m2b_reg;
    logic [DOT_W-1:0]  amag_reg;
    logic [4:0]        k_reg;
    logic              tneg3_reg, tinv3_reg;
    logic [DOT_W-1:0]  px_reg, py_reg;
    logic [6:0]        pbl_reg;
    logic              pneg3_reg, pinv3_reg;
    logic [4:0]        k_next;

    always_comb
    begin
        logic [6:0] bl;
        bl = bit_len(64'(m2_reg));
        k_next = (bl == '0) ? '0 : 5'((NORM_TOP - bl) >> 1);
    end

    always_ff @(posedge clk)
    begin
        m2b_reg   <= m2_reg;
        amag_reg  <= (dn_reg < 0) ? DOT_W'(-dn_reg) : DOT_W'(dn_reg);
        k_reg     <= k_next;
        tneg3_reg <= dn_reg < 0;
        tinv3_reg <= m2_reg == '0;
        px_reg    <= (dd_reg < 0) ? DOT_W'(-dd_reg) : DOT_W'(dd_reg);
        py_reg    <= (dt_reg < 0) ? DOT_W'(-dt_reg) : DOT_W'(dt_reg);
        pbl_reg   <= bit_len(64'($unsigned(dd_reg < 0 ? -dd_reg : dd_reg)
                     | $unsigned(dt_reg < 0 ? -dt_reg : dt_reg)));
        pneg3_reg <= dd_reg < 0;
        pinv3_reg <= (dd_reg == '0) && (dt_reg == '0);
    end

    // stage 4: normalizing shifts
    logic                 v4_reg;
    logic [ROOT_IN_W-1:0] m2n_reg;
    logic [NUM_W-1:0]     num4_reg;
    logic                 tneg4_reg, tinv4_reg;
    logic [PHI_W-1:0]     phi4_reg;
    logic [Q_FRAC-1:0]    xn_next, yn_next;

    always_comb
    begin
        logic [DOT_W-1:0] xs, ys;
        if (pbl_reg > PHI_TOP)
        begin
            xs = px_reg >> (pbl_reg - PHI_TOP);
            ys = py_reg >> (pbl_reg - PHI_TOP);
        end
        else
        begin
            xs = px_reg << (PHI_TOP - pbl_reg);
            ys = py_reg << (PHI_TOP - pbl_reg);
        end
        xn_next = xs[Q_FRAC-1:0];
        yn_next = ys[Q_FRAC-1:0];
    end

    always_ff @(posedge clk)
    begin
        m2n_reg   <= ROOT_IN_W'(m2b_reg) << {k_reg, 1'b0};
        num4_reg  <= NUM_W'(amag_reg) << k_reg;
        tneg4_reg <= tneg3_reg;
        tinv4_reg <= tinv3_reg;
        phi4_reg  <= {xn_next, yn_next, pneg3_reg, pinv3_reg};
    end

    // momentum length root
    logic                s1_valid;
    logic [ROOT_W-1:0]   s1_root;
    logic [TAG1_W-1:0]   s1_tag;

    tawf_isqrt #(.TAG_W(TAG1_W)) u_len_root (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v4_reg),
        .in_val    (m2n_reg),
        .in_tag    ({num4_reg, tneg4_reg, tinv4_reg, phi4_reg}),
        .out_valid (s1_valid),
        .out_root  (s1_root),
        .out_tag   (s1_tag)
    );

    // cosine divider: setup stage then one quotient bit per stage
    logic [DIV_STEPS:0] dvalid_reg;
    logic [REM_W-1:0]   drem_reg [DIV_STEPS+1];
    logic [DEN_W-1:0]   dden_reg [DIV_STEPS+1];
    logic [Q_FRAC-1:0]  dq_reg   [DIV_STEPS+1];
    logic               dsat_reg [DIV_STEPS+1];
    logic               dtneg_reg[DIV_STEPS+1];
    logic               dtinv_reg[DIV_STEPS+1];
    logic [PHI_W-1:0]   dphi_reg [DIV_STEPS+1];
    logic [REM_W-1:0]   drem_next[DIV_STEPS];
    logic [Q_FRAC-1:0]  dq_next  [DIV_STEPS];

    logic [NUM_W-1:0]   s1_num;
    logic [DEN_W-1:0]   s1_den;

    assign s1_num = s1_tag[TAG1_W-1 -: NUM_W];
    assign s1_den = {s1_root, {UNIT_FRAC{1'b0}}};

    always_comb
    begin
        for (int j = 0; j < DIV_STEPS; j++)
        begin
            logic [REM_W-1:0] sh;
            sh = {drem_reg[j][REM_W-2:0], 1'b0};
            if (sh >= {1'b0, dden_reg[j]})
            begin
                drem_next[j] = sh - {1'b0, dden_reg[j]};
                dq_next[j]   = {dq_reg[j][Q_FRAC-2:0], 1'b1};
            end
            else
            begin
                drem_next[j] = sh;
                dq_next[j]   = {dq_reg[j][Q_FRAC-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        drem_reg[0]  <= s1_num[REM_W-1:0];
        dden_reg[0]  <= s1_den;
        dq_reg[0]    <= '0;
        dsat_reg[0]  <= s1_num >= NUM_W'(s1_den);
        dtneg_reg[0] <= s1_tag[PHI_W+1];
        dtinv_reg[0] <= s1_tag[PHI_W];
        dphi_reg[0]  <= s1_tag[PHI_W-1:0];
        for (int j = 0; j < DIV_STEPS; j++)
        begin
            drem_reg[j+1]  <= drem_next[j];
            dden_reg[j+1]  <= dden_reg[j];
            dq_reg[j+1]    <= dq_next[j];
            dsat_reg[j+1]  <= dsat_reg[j];
            dtneg_reg[j+1] <= dtneg_reg[j];
            dtinv_reg[j+1] <= dtinv_reg[j];
            dphi_reg[j+1]  <= dphi_reg[j];
        end
    end

    // stage 6: cosine squared
    logic                   v6_reg;
    logic [CORD_IN_W-1:0]   q6_reg;
    logic [2*CORD_IN_W-1:0] qsq6_reg;
    logic                   tneg6_reg, tinv6_reg;
    logic [PHI_W-1:0]       phi6_reg;
    logic [CORD_IN_W-1:0]   q_next;

    assign q_next = dsat_reg[DIV_STEPS] ? (CORD_IN_W'(1) << Q_FRAC)
                                        : {1'b0, dq_reg[DIV_STEPS]};

    always_ff @(posedge clk)
    begin
        q6_reg    <= q_next;
        qsq6_reg  <= (2*CORD_IN_W)'(q_next) * (2*CORD_IN_W)'(q_next);
        tneg6_reg <= dtneg_reg[DIV_STEPS];
        tinv6_reg <= dtinv_reg[DIV_STEPS];
        phi6_reg  <= dphi_reg[DIV_STEPS];
    end

    // sine root
    logic              s2_valid;
    logic [ROOT_W-1:0] s2_root;
    logic [TAG2_W-1:0] s2_tag;

    tawf_isqrt #(.TAG_W(TAG2_W)) u_sin_root (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v6_reg),
        .in_val    ((ROOT_IN_W'(1) << (2 * Q_FRAC)) - ROOT_IN_W'(qsq6_reg)),
        .in_tag    ({q6_reg, tneg6_reg, tinv6_reg, phi6_reg}),
        .out_valid (s2_valid),
        .out_root  (s2_root),
        .out_tag   (s2_tag)
    );

    logic [PHI_W-1:0] s2_phi;
    assign s2_phi = s2_tag[PHI_W-1:0];

    logic               th_valid, ph_valid;
    logic [ANGLE_W-1:0] th_angle, ph_angle;
    logic               th_inv, ph_inv;

    tawf_cordic #(.TAG_W(1)) u_theta_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid),
        .in_x      (s2_tag[TAG2_W-1 -: CORD_IN_W]),
        .in_y      (s2_root[CORD_IN_W-1:0]),
        .in_neg    (s2_tag[PHI_W+1]),
        .in_tag    (s2_tag[PHI_W]),
        .out_valid (th_valid),
        .out_angle (th_angle),
        .out_tag   (th_inv)
    );

    tawf_cordic #(.TAG_W(1)) u_phi_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid),
        .in_x      ({1'b0, s2_phi[PHI_W-1 -: Q_FRAC]}),
        .in_y      ({1'b0, s2_phi[Q_FRAC+1 -: Q_FRAC]}),
        .in_neg    (s2_phi[1]),
        .in_tag    (s2_phi[0]),
        .out_valid (ph_valid),
        .out_angle (ph_angle),
        .out_tag   (ph_inv)
    );

    // valid bits of the front stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            v3_reg     <= 1'b0;
            v4_reg     <= 1'b0;
            dvalid_reg <= '0;
            v6_reg     <= 1'b0;
        end
        else
        begin
            v1_reg     <= start && !busy;
            v2_reg     <= v1_reg;
            v3_reg     <= v2_reg;
            v4_reg     <= v3_reg;
            dvalid_reg <= {dvalid_reg[DIV_STEPS-1:0], s1_valid};
            v6_reg     <= dvalid_reg[DIV_STEPS];
        end
    end

    assign done          = th_valid;
    assign theta         = th_inv ? '0 : th_angle;
    assign phi           = ph_inv ? '0 : ph_angle;
    assign theta_invalid = th_inv;
    assign phi_invalid   = ph_inv;

    a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LATENCY done)
        else $error("beat did not come out after fixed latency");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("result without matching start beat");

    a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        th_valid == ph_valid)
        else $error("theta and phi lanes out of step");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (theta <= ANGLE_PI) && (phi <= ANGLE_PI))
        else $error("angle beyond pi");

endmodule

>>> verif/tb.sv
// Testbench for the track angle pipeline: random and directed beats against a local predictor.
module tb;
    import tawf_pkg::*;

    typedef struct {
        logic signed [MOM_W-1:0]  m [3];
        logic signed [UNIT_W-1:0] n [3];
        logic signed [UNIT_W-1:0] d [3];
        logic signed [UNIT_W-1:0] t [3];
        int                       gap;
        bit                       drain;
    } track_t;

    typedef struct {
        logic [ANGLE_W-1:0] theta;
        logic [ANGLE_W-1:0] phi;
        logic               theta_inv;
        logic               phi_inv;
    } angles_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [MOM_W-1:0]  mom_x = '0, mom_y = '0, mom_z = '0;
    logic signed [UNIT_W-1:0] normal_x = '0, normal_y = '0, normal_z = '0;
    logic signed [UNIT_W-1:0] drift_x = '0, drift_y = '0, drift_z = '0;
    logic signed [UNIT_W-1:0] transverse_x = '0, transverse_y = '0, transverse_z = '0;
    logic done;
    logic [ANGLE_W-1:0] theta, phi;
    logic theta_invalid, phi_invalid;

    track_t  pending_tracks [$];
    angles_t expected_angles [$];
    int      error_count = 0;
    bit      stim_done = 1'b0;
    int      gap_left = 0;

    always #5 clk = ~clk;

    track_angles_to_wafer_frame dut (.*);

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint trunc_shift(longint v, int i);
        return (v >= 0) ? (v >>> i) : -((-v) >>> i);
    endfunction

    function automatic logic [ANGLE_W-1:0] cordic_angle(longint x, longint y, bit neg);
        longint z, dx, dy, a;
        z = 0;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            dx = trunc_shift(y, i);
            dy = trunc_shift(x, i);
            if (y >= 0)
            begin
                x += dx; y -= dy; z += longint'(atan_q30(i));
            end
            else
            begin
                x -= dx; y += dy; z -= longint'(atan_q30(i));
            end
        end
        if (z < 0) z = 0;
        if (z > longint'(HALF_PI_Q30)) z = longint'(HALF_PI_Q30);
        a = neg ? longint'(PI_Q30) - z : z;
        return ANGLE_W'((a + (64'sd1 << (Q_FRAC - 1 - ANGLE_FRAC))) >>> (Q_FRAC - ANGLE_FRAC));
    endfunction

    function automatic angles_t predict_angles(track_t tr);
        angles_t res;
        longint a, vd, vt;
        longint unsigned m2, r, num, den, q, s, x, y;
        int k;
        a = 0; vd = 0; vt = 0; m2 = 0; k = 0;
        for (int i = 0; i < 3; i++)
        begin
            a  += longint'(tr.m[i]) * longint'(tr.n[i]);
            vd += longint'(tr.m[i]) * longint'(tr.d[i]);
            vt += longint'(tr.m[i]) * longint'(tr.t[i]);
            m2 += longint'(tr.m[i]) * longint'(tr.m[i]);
        end
        res = '{default: '0};
        if (m2 == 0)
            res.theta_inv = 1'b1;
        else
        begin
            while ((m2 >> 60) == 0)
            begin
                m2 <<= 2;
                k++;
            end
            r = int_sqrt(m2);
            num = (a < 0 ? -a : a) << k;
            den = r << UNIT_FRAC;
            if (num >= den)
                q = 64'd1 << 30;
            else
            begin
                q = 0;
                for (int i = 0; i < 30; i++)
                begin
                    num <<= 1;
                    q <<= 1;
                    if (num >= den)
                    begin
                        num -= den;
                        q |= 1;
                    end
                end
            end
            s = int_sqrt((64'd1 << 60) - q * q);
            res.theta = cordic_angle(q, s, a < 0);
        end
        if (vd == 0 && vt == 0)
            res.phi_inv = 1'b1;
        else
        begin
            x = vd < 0 ? -vd : vd;
            y = vt < 0 ? -vt : vt;
            while ((x > y ? x : y) >= (64'd1 << 30))
            begin
                x >>= 1; y >>= 1;
            end
            while ((x > y ? x : y) < (64'd1 << 29))
            begin
                x <<= 1; y <<= 1;
            end
            res.phi = cordic_angle(x, y, vd < 0);
        end
        return res;
    endfunction

    function automatic logic signed [UNIT_W-1:0] rand_unit();
        case ($urandom_range(0, 5))
            0: return UNIT_W'($urandom);
            1: return 16'sd16384;
            2: return -16'sd16384;
            3: return '0;
            default: return UNIT_W'($urandom_range(0, 32768)) - 16'sd16384;
        endcase
    endfunction

    function automatic logic signed [MOM_W-1:0] rand_mom();
        case ($urandom_range(0, 6))
            0: return '0;
            1: return MOM_W'($urandom_range(0, 15)) - 24'sd8;
            2: return 24'sh7fffff;
            3: return 24'sh800000;
            default: return MOM_W'($urandom) >>> $urandom_range(0, 22);
        endcase
    endfunction

    // orthonormal-ish frame from a permutation of axes with random signs, or random components
    function automatic track_t rand_track();
        track_t tr;
        int p;
        p = $urandom_range(0, 2);
        for (int i = 0; i < 3; i++)
        begin
            tr.m[i] = rand_mom();
            tr.n[i] = '0; tr.d[i] = '0; tr.t[i] = '0;
        end
        if ($urandom_range(0, 3) == 0)
            for (int i = 0; i < 3; i++)
            begin
                tr.n[i] = rand_unit(); tr.d[i] = rand_unit(); tr.t[i] = rand_unit();
            end
        else
        begin
            tr.n[p]       = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
            tr.d[(p+1)%3] = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
            tr.t[(p+2)%3] = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
        end
        tr.gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
               : (($urandom_range(0, 2) == 0) ? $urandom_range(0, 2) : 0);
        tr.drain = 1'b0;
        return tr;
    endfunction

    function automatic track_t make_track(longint mx, longint my, longint mz,
                                          int nx, int ny, int nz, int dx, int dy, int dz,
                                          int tx, int ty, int tz);
        track_t tr;
        tr.m[0] = MOM_W'(mx); tr.m[1] = MOM_W'(my); tr.m[2] = MOM_W'(mz);
        tr.n[0] = UNIT_W'(nx); tr.n[1] = UNIT_W'(ny); tr.n[2] = UNIT_W'(nz);
        tr.d[0] = UNIT_W'(dx); tr.d[1] = UNIT_W'(dy); tr.d[2] = UNIT_W'(dz);
        tr.t[0] = UNIT_W'(tx); tr.t[1] = UNIT_W'(ty); tr.t[2] = UNIT_W'(tz);
        tr.gap = 0;
        tr.drain = 1'b0;
        return tr;
    endfunction

    initial
    begin
        track_t tr;
        // zero momentum, zero in-plane projection, axis cases, extremes
        pending_tracks.push_back(make_track(0, 0, 0, 0, 0, 16384, 16384, 0, 0, 0, 16384, 0));
        pending_tracks.push_back(make_track(0, 0, 100, 0, 0, 16384, 16384, 0, 0, 0, 16384, 0));
        pending_tracks.push_back(make_track(0, 0, -100, 0, 0, 16384, 16384, 0, 0, 0, 16384, 0));
        pending_tracks.push_back(make_track(5, 0, 0, 0, 0, 16384, 16384, 0, 0, 0, 16384, 0));
        pending_tracks.push_back(make_track(-5, 0, 0, 0, 0, 16384, 16384, 0, 0, 0, 16384, 0));
        pending_tracks.push_back(make_track(0, 7, 0, 0, 0, 16384, 16384, 0, 0, 0, 16384, 0));
        pending_tracks.push_back(make_track(0, -7, 0, 0, 0, 16384, 16384, 0, 0, 0, 16384, 0));
        pending_tracks.push_back(make_track(8388607, 8388607, 8388607,
            16384, 16384, 16384, 16384, 16384, 16384, 16384, 16384, 16384));
        pending_tracks.push_back(make_track(-8388608, -8388608, -8388608,
            -16384, -16384, -16384, -16384, -16384, -16384, -16384, -16384, -16384));
        pending_tracks.push_back(make_track(-8388608, 8388607, 1,
            32767, -32768, 0, -32768, 32767, 1, 32767, 32767, -32768));
        pending_tracks.push_back(make_track(1, 1, 1, 11585, 11585, 0, 11585, -11585, 0,
            0, 0, 16384));
        pending_tracks.push_back(make_track(3, -4, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_tracks.push_back(make_track(1, 0, 0, 16384, 0, 0, 0, 16384, 0, 0, 0, 16384));
        pending_tracks.push_back(make_track(100, 100, 0, 0, 0, 16384, 16384, 0, 0,
            0, -16384, 0));
        pending_tracks.push_back(make_track(-100, 100, 0, 0, 0, 16384, 16384, 0, 0,
            0, 16384, 0));
        for (int i = 0; i < 1900; i++)
        begin
            tr = rand_track();
            tr.drain = (i == 600 || i == 1300);
            pending_tracks.push_back(tr);
        end
        stim_done = 1'b1;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    // driver; a drain beat waits until every earlier result has come back
    always @(posedge clk)
    begin
        track_t tr;
        if (!rst_n || busy === 1'bx)
            start <= 1'b0;
        else if (start && busy)
            start <= 1'b1;
        else if (gap_left > 0)
        begin
            gap_left <= gap_left - 1;
            start <= 1'b0;
        end
        else if (pending_tracks.size() > 0 &&
                 !(pending_tracks[0].drain && expected_angles.size() != 0))
        begin
            tr = pending_tracks.pop_front();
            expected_angles.push_back(predict_angles(tr));
            {mom_x, mom_y, mom_z} <= {tr.m[0], tr.m[1], tr.m[2]};
            {normal_x, normal_y, normal_z} <= {tr.n[0], tr.n[1], tr.n[2]};
            {drift_x, drift_y, drift_z} <= {tr.d[0], tr.d[1], tr.d[2]};
            {transverse_x, transverse_y, transverse_z} <= {tr.t[0], tr.t[1], tr.t[2]};
            start <= 1'b1;
            gap_left <= tr.gap;
        end
        else
            start <= 1'b0;
    end

    // predictions are queued when the beat is driven; a beat is accepted at the next edge
    // with start high and busy low, and busy stays low, so the order matches.
    always @(posedge clk)
    begin
        angles_t want;
        if (rst_n && done)
        begin
            if (expected_angles.size() == 0)
            begin
                $display("%0t: unexpected result theta=%0d phi=%0d", $time, theta, phi);
                error_count++;
            end
            else
            begin
                want = expected_angles.pop_front();
                if (theta !== want.theta || phi !== want.phi ||
                    theta_invalid !== want.theta_inv || phi_invalid !== want.phi_inv)
                begin
                    $display({"%0t: mismatch expected theta=%0d phi=%0d ti=%0b pi=%0b,",
                              " got %0d %0d %0b %0b"},
                        $time, want.theta, want.phi, want.theta_inv, want.phi_inv,
                        theta, phi, theta_invalid, phi_invalid);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        wait (stim_done);
        wait (rst_n && pending_tracks.size() == 0 && !start);
        wait (expected_angles.size() == 0);
        repeat (200) @(posedge clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end
endmodule

>>> sim.f
hw/rtl/tawf_pkg.sv
hw/rtl/tawf_isqrt.sv
hw/rtl/tawf_cordic.sv
hw/rtl/track_angles_to_wafer_frame.sv
verif/tb.sv
